FILE: design/lpht_pkg.sv
package lpht_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int KEY_BYTES_DEF  = 8;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [4:0]  MAX_FILL_RESET = 5'd9;
  localparam logic [63:0] FNV_OFFSET     = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME      = 64'h00000100000001b3;

  localparam logic [1:0] KIND_PUT     = 2'd0;
  localparam logic [1:0] KIND_GET     = 2'd1;
  localparam logic [1:0] KIND_DEL     = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_MISSING  = 3'd3;
  localparam logic [2:0] ST_DELETED  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

endpackage

FILE: design/linear_probe_hash_table_top.sv
// Hash table with linear probing, put/get/delete of 64-bit keys.
// Input channel: push/full; a transaction is taken when push && !full.
// Result channel: empty/pop; status, read_value and entry_total are valid
// while empty is low, and are retired when pop && !empty.
// Configuration: cfg_valid/cfg_ready write max_fill; cfg_ready is low while
// any transaction is in flight or being pushed.
// The front computes the FNV-1a hash one key byte at a time: an xor step, then
// a multiply that sums three 32x32 partial products in MUL. The back then
// reads the slots one after another from the home slot, each through states
// RD and PROBE. A delete additionally walks the following cluster, each entry
// through DEL_RD, DEL_CHK, REHASH and PLACE. The front takes a new transaction
// once it hands the last one to the back, so it can hash the next key while
// the back is still working on the previous one.
// Reset empties the table and sets max_fill to 9.
// A result held because pop is low stalls the probe unit; the front
// then finishes its hash and holds it until the back is free.
module linear_probe_hash_table_top #(
  parameter int SLOT_COUNT = lpht_pkg::SLOT_COUNT_DEF,
  parameter int KEY_BYTES  = lpht_pkg::KEY_BYTES_DEF,
  parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [63:0] key,
  input  logic [31:0] value,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [31:0] read_value,
  output logic [4:0]  entry_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  localparam int SW = $clog2(SLOT_COUNT);

  logic [4:0]            max_fill;
  logic                  q_valid, q_ready, busy;
  logic [1:0]            q_kind;
  logic [63:0]           q_key;
  logic [VALUE_BITS-1:0] q_value;
  logic [SW-1:0]         q_home;

  assign cfg_ready = !full && !busy && !push;

  always_ff @(posedge clk) begin
    if (rst) max_fill <= lpht_pkg::MAX_FILL_RESET;
    else if (cfg_valid && cfg_ready) max_fill <= cfg_data;
  end

  lpht_front #(.SLOT_COUNT(SLOT_COUNT), .KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS))
  u_front (
    .clk, .rst, .push, .full, .kind, .key, .value,
    .q_valid, .q_ready, .q_kind, .q_key, .q_value, .q_home
  );

  lpht_back #(.SLOT_COUNT(SLOT_COUNT), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst, .max_fill, .busy,
    .q_valid, .q_ready, .q_kind, .q_key, .q_value, .q_home,
    .empty, .pop, .status, .read_value, .entry_total
  );

endmodule

FILE: design/lpht_front.sv
module lpht_front #(
  parameter int SLOT_COUNT = lpht_pkg::SLOT_COUNT_DEF,
  parameter int KEY_BYTES  = lpht_pkg::KEY_BYTES_DEF,
  parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF,
  localparam int SW = $clog2(SLOT_COUNT)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            kind,
  input  logic [63:0]           key,
  input  logic [31:0]           value,
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic [1:0]            q_kind,
  output logic [63:0]           q_key,
  output logic [VALUE_BITS-1:0] q_value,
  output logic [SW-1:0]         q_home
);

  localparam int KB = 8 * KEY_BYTES;
  localparam logic [63:0] KMASK = {64{1'b1}} >> (64 - KB);

  typedef enum logic [1:0] {IDLE, XOR, MUL, DONE} state_t;

  // One byte at a time, through XOR and then MUL; 64-bit multiply split into 32x32 products.
  state_t                state;
  logic [1:0]            h_kind;
  logic [63:0]           h_key;
  logic [VALUE_BITS-1:0] h_value;
  logic [63:0]           h;
  logic [3:0]            byte_idx;
  logic [1:0]            part;
  logic [63:0]           acc;
  logic [63:0]           prod;

  always_comb begin
    case (part)
      2'd0: prod = 64'(h[31:0] * lpht_pkg::FNV_PRIME[31:0]);
      2'd1: prod = 64'(h[31:0] * lpht_pkg::FNV_PRIME[63:32]) << 32;
      2'd2: prod = 64'(h[63:32] * lpht_pkg::FNV_PRIME[31:0]) << 32;
      default: prod = 64'd0;
    endcase
  end

  assign full    = (state != IDLE);
  assign q_valid = (state == DONE);
  assign q_kind  = h_kind;
  assign q_key   = h_key;
  assign q_value = h_value;
  assign q_home  = h[SW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (push) begin
            h_kind   <= kind;
            h_key    <= key & KMASK;
            h_value  <= VALUE_BITS'(value);
            h        <= lpht_pkg::FNV_OFFSET;
            byte_idx <= '0;
            state    <= XOR;
          end
        end
        XOR: begin
          h     <= h ^ {56'd0, h_key[8*byte_idx[2:0] +: 8]};
          part  <= 2'd0;
          acc   <= 64'd0;
          state <= MUL;
        end
        MUL: begin
          if (part == 2'd3) begin
            h        <= acc;
            byte_idx <= byte_idx + 4'd1;
            state    <= (byte_idx + 4'd1 == 4'(KEY_BYTES)) ? DONE : XOR;
          end else begin
            acc  <= acc + prod;
            part <= part + 2'd1;
          end
        end
        DONE: begin
          if (q_ready) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: design/lpht_back.sv
module lpht_back #(
  parameter int SLOT_COUNT = lpht_pkg::SLOT_COUNT_DEF,
  parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF,
  localparam int SW = $clog2(SLOT_COUNT)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [4:0]            max_fill,
  output logic                  busy,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [1:0]            q_kind,
  input  logic [63:0]           q_key,
  input  logic [VALUE_BITS-1:0] q_value,
  input  logic [SW-1:0]         q_home,
  output logic                  empty,
  input  logic                  pop,
  output logic [2:0]            status,
  output logic [31:0]           read_value,
  output logic [4:0]            entry_total
);

  localparam int CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [2:0] {
    IDLE, RD, PROBE, DEL_RD, DEL_CHK, REHASH, PLACE, OUT
  } state_t;

  // Keys, values and home slots live in memories with registered reads;
  // valid bits in flops.
  logic [63:0]           mem_key [SLOT_COUNT];
  logic [VALUE_BITS-1:0] mem_val [SLOT_COUNT];
  logic [SW-1:0]         mem_home [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] used;

  state_t                state;
  logic [1:0]            op_kind;
  logic [63:0]           op_key;
  logic [VALUE_BITS-1:0] op_value;
  logic [SW-1:0]         op_home;
  logic [SW-1:0]         ptr;
  logic [SW-1:0]         gap;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         cleanup;
  logic [CW-1:0]         entries;
  logic [63:0]           rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic [SW-1:0]         rd_home;
  logic [SW-1:0]         rd_addr;
  logic                  wr_en;
  logic [SW-1:0]         wr_addr;
  logic [63:0]           wr_key;
  logic [VALUE_BITS-1:0] wr_val;
  logic [SW-1:0]         wr_home;
  logic [SW-1:0]         ptr_inc;
  logic [SW-1:0]         home_r;
  logic                  hit;
  logic                  room;

  // Reinsertion: a moved entry goes to the gap unless its home lies
  // cyclically in (gap, ptr], in which case it stays.
  logic stays;
  always_comb begin
    if (gap <= ptr) stays = (home_r > gap) && (home_r <= ptr);
    else            stays = (home_r > gap) || (home_r <= ptr);
  end

  assign ptr_inc = (32'(ptr) + 1 >= SLOT_COUNT) ? '0 : SW'(32'(ptr) + 1);
  assign q_ready = (state == IDLE);
  assign busy    = (state != IDLE);
  assign empty   = (state != OUT);
  assign home_r  = rd_home;
  assign hit     = used[ptr] && (rd_key == op_key);
  assign room    = (32'(entries) < 32'(max_fill));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_key  = op_key;
    wr_val  = op_value;
    wr_home = op_home;
    if (state == PROBE && op_kind == lpht_pkg::KIND_PUT && (hit || (!used[ptr] && room))) begin
      wr_en = 1'b1;
    end else if (state == PLACE && !stays) begin
      wr_en   = 1'b1;
      wr_addr = gap;
      wr_key  = rd_key;
      wr_val  = rd_val;
      wr_home = rd_home;
    end
  end

  always_ff @(posedge clk) begin
    rd_key  <= mem_key[rd_addr];
    rd_val  <= mem_val[rd_addr];
    rd_home <= mem_home[rd_addr];
    if (wr_en) begin
      mem_key[wr_addr]  <= wr_key;
      mem_val[wr_addr]  <= wr_val;
      mem_home[wr_addr] <= wr_home;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      used        <= '0;
      entries     <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (q_valid) begin
            op_kind  <= q_kind;
            op_key   <= q_key;
            op_value <= q_value;
            op_home  <= q_home;
            ptr      <= q_home;
            rd_addr  <= q_home;
            cnt      <= '0;
            state    <= RD;
          end
        end
        RD: state <= PROBE;
        PROBE: begin
          read_value <= (hit && (op_kind inside {lpht_pkg::KIND_GET, lpht_pkg::KIND_DEL}))
                        ? 32'(rd_val) : 32'd0;
          if (!used[ptr] || hit) begin
            if (used[ptr]) begin
              if (op_kind == lpht_pkg::KIND_PUT) begin
                status <= lpht_pkg::ST_UPDATED;
                state <= OUT;
              end else if (op_kind == lpht_pkg::KIND_GET) begin
                status <= lpht_pkg::ST_FOUND;
                state <= OUT;
              end else if (op_kind == lpht_pkg::KIND_DEL) begin
                status <= lpht_pkg::ST_DELETED;
                used[ptr] <= 1'b0;
                if (entries != '0) entries <= entries - 1'b1;
                gap <= ptr;
                ptr <= ptr_inc;
                cleanup <= CW'(1);
                state <= DEL_RD;
              end else begin
                status <= lpht_pkg::ST_MISSING;
                state <= OUT;
              end
            end else begin
              if (op_kind == lpht_pkg::KIND_PUT) begin
                if (!room) begin
                  status <= lpht_pkg::ST_FULL;
                end else begin
                  used[ptr] <= 1'b1;
                  entries <= entries + 1'b1;
                  status <= lpht_pkg::ST_INSERTED;
                end
              end else begin
                status <= lpht_pkg::ST_MISSING;
              end
              state <= OUT;
            end
          end else if (32'(cnt) + 1 >= SLOT_COUNT) begin
            status <= (op_kind == lpht_pkg::KIND_PUT) ? lpht_pkg::ST_FULL
                                                      : lpht_pkg::ST_MISSING;
            state <= OUT;
          end else begin
            cnt <= cnt + 1'b1;
            ptr <= ptr_inc;
            rd_addr <= ptr_inc;
            state <= RD;
          end
        end
        DEL_RD: begin
          rd_addr <= ptr;
          if (!used[ptr] || 32'(cleanup) >= SLOT_COUNT) state <= OUT;
          else state <= DEL_CHK;
        end
        DEL_CHK: state <= REHASH;
        REHASH: state <= PLACE;
        PLACE: begin
          if (!stays) begin
            used[gap] <= 1'b1;
            used[ptr] <= 1'b0;
            gap <= ptr;
          end
          ptr <= ptr_inc;
          cleanup <= cleanup + 1'b1;
          state <= DEL_RD;
        end
        OUT: begin
          if (pop) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign entry_total = 5'(entries);

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    32'(entries) <= SLOT_COUNT) else $error("entry count overflow");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    (state == OUT && pop) |=> state == IDLE) else $error("result not retired");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state == OUT && !pop) |=> (state == OUT && $stable(status) && $stable(read_value)))
    else $error("waiting result changed");
`endif

endmodule
